[hw/rtl/vsff_pkg.sv]
// Shared types and constants for the voxel scanline flood fill block.
`timescale 1ns / 1ps
package vsff_pkg;
    localparam int X_BITS      = 7;
    localparam int Z_BITS      = 7;
    localparam int HEIGHT_BITS = 6;
    localparam int STACK_DEPTH = 65536;
    localparam int ADDR_W      = X_BITS + Z_BITS + HEIGHT_BITS;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 21;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_FLOOD = 2'd2;

    localparam logic [2:0] CFG_XL    = 3'd0;
    localparam logic [2:0] CFG_ZL    = 3'd1;
    localparam logic [2:0] CFG_STONE = 3'd2;
    localparam logic [2:0] CFG_WATER = 3'd3;
    localparam logic [2:0] CFG_SWATER = 3'd4;
    localparam logic [2:0] CFG_LAVA  = 3'd5;
    localparam logic [2:0] CFG_SLAVA = 3'd6;

    typedef struct packed {
        logic [3:0] xl;
        logic [3:0] zl;
        logic [7:0] stone;
        logic [7:0] water;
        logic [7:0] swater;
        logic [7:0] lava;
        logic [7:0] slava;
    } cfg_t;

    // one memory port request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;
endpackage

[hw/rtl/voxel_scanline_flood_fill.sv]
// Top level of the voxel grid with scanline flood fill.
// Use: s_axis carries one request item (write, read or flood); m_axis returns one
// result item per request. The user must write the seven cfg registers by index only
// while idle; the block does not enforce it. A write or read makes one grid access;
// a flood walks the grid memory access by access: each seed is popped from the stack
// and its cell read and checked, each cell scanned along the row is read and checked,
// each cell filled is written and its neighbors are probed, plus a stone write when
// water turns to stone, so its length depends on the region.
// One request at a time is in flight; the single-port grid memory and the seed
// stack memory set the pace.
// Reset clears control state and config; grid and stack contents are undefined
// until written, so load the grid before reading it.
// A stalled m_axis holds its result; one more request is taken and runs, then waits
// for the result register, and s_axis_tready stays low until that request is out.
// On stack overflow the flood stops and returns the count so far with the flag set.
`timescale 1ns / 1ps
module voxel_scanline_flood_fill
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pos_x[6:0], pos_y[12:7], pos_z[19:13], cell_value[27:20]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_value[7:0], filled_count[28:8], stack_overflow[29]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import vsff_pkg::*;

    cfg_t              cfg;
    mem_req_t          gm;
    logic [7:0]        grd;
    logic              st_we, st_re;
    logic [SA_W-1:0]   st_addr;
    logic [ADDR_W-1:0] st_wdata, st_rdata;
    logic [7:0]        read_value;
    logic [CNT_W-1:0]  filled_count;
    logic              stack_overflow;

    vsff_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    vsff_engine u_eng (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .req_type(s_axis_tuser), .pos_x(s_axis_tdata[6:0]), .pos_y(s_axis_tdata[12:7]),
        .pos_z(s_axis_tdata[19:13]), .cell_value(s_axis_tdata[27:20]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .read_value(read_value), .filled_count(filled_count),
        .stack_overflow(stack_overflow),
        .gm(gm), .grd(grd),
        .st_we(st_we), .st_re(st_re), .st_addr(st_addr), .st_wdata(st_wdata),
        .st_rdata(st_rdata)
    );

    vsff_grid_ram u_grid (.clk(clk), .req(gm), .rdata(grd));

    vsff_stack_ram u_stack (
        .clk(clk), .we(st_we), .re(st_re), .addr(st_addr), .wdata(st_wdata),
        .rdata(st_rdata)
    );

    assign m_axis_tdata = {2'b00, stack_overflow, filled_count, read_value};
endmodule

[hw/rtl/vsff_grid_ram.sv]
// Single-port voxel grid memory with registered read data.
`timescale 1ns / 1ps
module vsff_grid_ram
(
    input  logic                clk,
    input  vsff_pkg::mem_req_t  req,
    output logic [7:0]          rdata
);
    import vsff_pkg::*;
    logic [7:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem[req.addr] <= req.wdata;
            else
                rdata <= mem[req.addr];
        end
    end
endmodule

[hw/rtl/vsff_stack_ram.sv]
// Seed stack memory, one write or one read per cycle.
`timescale 1ns / 1ps
module vsff_stack_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic                        re,
    input  logic [vsff_pkg::SA_W-1:0]   addr,
    input  logic [vsff_pkg::ADDR_W-1:0] wdata,
    output logic [vsff_pkg::ADDR_W-1:0] rdata
);
    import vsff_pkg::*;
    logic [ADDR_W-1:0] mem [0:STACK_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else if (re)
            rdata <= mem[addr];
    end
endmodule

[hw/rtl/vsff_cfg_regs.sv]
// Configuration registers with clamped log2 sizes.
`timescale 1ns / 1ps
module vsff_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output vsff_pkg::cfg_t      cfg
);
    import vsff_pkg::*;
    logic [2:0] xl_reg, zl_reg;
    logic [7:0] stone_reg, water_reg, swater_reg, lava_reg, slava_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xl_reg     <= 3'd7;
            zl_reg     <= 3'd7;
            stone_reg  <= 8'd1;
            water_reg  <= 8'd8;
            swater_reg <= 8'd9;
            lava_reg   <= 8'd10;
            slava_reg  <= 8'd11;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_XL:     xl_reg     <= cfg_data[2:0];
                CFG_ZL:     zl_reg     <= cfg_data[2:0];
                CFG_STONE:  stone_reg  <= cfg_data;
                CFG_WATER:  water_reg  <= cfg_data;
                CFG_SWATER: swater_reg <= cfg_data;
                CFG_LAVA:   lava_reg   <= cfg_data;
                CFG_SLAVA:  slava_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.xl = (xl_reg == 3'd0) ? 4'd1 :
                 ({1'b0, xl_reg} > 4'(X_BITS)) ? 4'(X_BITS) : {1'b0, xl_reg};
        cfg.zl = (zl_reg == 3'd0) ? 4'd1 :
                 ({1'b0, zl_reg} > 4'(Z_BITS)) ? 4'(Z_BITS) : {1'b0, zl_reg};
        cfg.stone  = stone_reg;
        cfg.water  = water_reg;
        cfg.swater = swater_reg;
        cfg.lava   = lava_reg;
        cfg.slava  = slava_reg;
    end
endmodule

[hw/rtl/vsff_engine.sv]
// Request sequencer: cell write/read and the scanline flood walk over the grid memory.
`timescale 1ns / 1ps
module vsff_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  vsff_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [6:0]                  pos_x,
    input  logic [5:0]                  pos_y,
    input  logic [6:0]                  pos_z,
    input  logic [7:0]                  cell_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  read_value,
    output logic [vsff_pkg::CNT_W-1:0]  filled_count,
    output logic                        stack_overflow,
    output vsff_pkg::mem_req_t          gm,
    input  logic [7:0]                  grd,
    output logic                        st_we,
    output logic                        st_re,
    output logic [vsff_pkg::SA_W-1:0]   st_addr,
    output logic [vsff_pkg::ADDR_W-1:0] st_wdata,
    input  logic [vsff_pkg::ADDR_W-1:0] st_rdata
);
    import vsff_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_READ_WAIT, S_SEED_RD, S_SEED_CHK, S_POP, S_POP_WAIT, S_POP_RD,
        S_POP_CHK, S_LO_RD, S_LO_CHK, S_HI_RD, S_HI_CHK, S_FILL_WR,
        S_N1_RD, S_N1_CHK, S_N2_RD, S_N2_CHK, S_N3_RD, S_N3_CHK, S_STONE_WR,
        S_NEXT, S_DONE
    } state_t;

    localparam logic [ADDR_W-1:0] ONE = ADDR_W'(1);

    state_t            state_reg;
    logic [ADDR_W-1:0] addr_reg;      // base of the current row
    logic [X_BITS:0]   lo_reg, hi_reg, c_reg;
    logic [ADDR_W-1:0] cz_reg;
    logic [HEIGHT_BITS-1:0] cy_reg;
    logic [7:0]        v_reg;
    logic              lava_reg, p1_reg, p2_reg, p3_reg, ovf_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [7:0]        rval_reg;
    logic              ovalid_reg;
    logic [7:0]        res_rv_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic              res_ovf_reg;

    logic [ADDR_W-1:0] w_cells, layer_cells, xmask, zmask, g, idx;
    logic [ADDR_W-1:0] push_addr;
    logic              push_want;

    always_comb
    begin
        w_cells     = ONE << cfg.xl;
        layer_cells = ONE << (cfg.xl + cfg.zl);
        xmask       = w_cells - ONE;
        zmask       = (ONE << cfg.zl) - ONE;
        idx = ((ADDR_W'(pos_y)) << (cfg.xl + cfg.zl))
            | ((ADDR_W'(pos_z) & zmask) << cfg.xl)
            | (ADDR_W'(pos_x) & xmask);
        g = addr_reg + ADDR_W'(c_reg);
    end

    // the result register parts the two sides: a new request runs while a result waits
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = ovalid_reg;
    assign read_value     = res_rv_reg;
    assign filled_count   = res_cnt_reg;
    assign stack_overflow = res_ovf_reg;

    // memory requests are decoded from the state; read data returns in the next cycle
    always_comb
    begin
        gm        = '0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_addr   = sp_reg[SA_W-1:0];
        st_wdata  = '0;
        push_want = 1'b0;
        push_addr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    gm.addr  = idx;
                    gm.wdata = cell_value;
                    gm.en    = (req_type == REQ_WRITE) || (req_type == REQ_READ) ||
                               ((req_type == REQ_FLOOD) && (cell_value != 8'd0));
                    gm.we    = (req_type == REQ_WRITE);
                end
            end
            S_SEED_CHK:
            begin
                st_we    = (grd == 8'd0);
                st_addr  = '0;
                st_wdata = addr_reg;
            end
            S_POP:
            begin
                st_re   = 1'b1;
                st_addr = SA_W'(sp_reg - SP_W'(1));
            end
            S_POP_RD:   begin gm.en = 1'b1; gm.addr = st_rdata; end
            S_LO_RD:    begin gm.en = 1'b1; gm.addr = addr_reg + ADDR_W'(lo_reg) - ONE; end
            S_HI_RD:    begin gm.en = 1'b1; gm.addr = addr_reg + ADDR_W'(hi_reg); end
            S_FILL_WR:  begin gm.en = 1'b1; gm.we = 1'b1; gm.addr = g; gm.wdata = v_reg; end
            S_N1_RD:    begin gm.en = 1'b1; gm.addr = g - w_cells; end
            S_N2_RD:    begin gm.en = 1'b1; gm.addr = g + w_cells; end
            S_N3_RD:    begin gm.en = 1'b1; gm.addr = g - layer_cells; end
            S_STONE_WR:
            begin
                gm.en = 1'b1; gm.we = 1'b1; gm.addr = g - layer_cells; gm.wdata = cfg.stone;
            end
            S_N1_CHK:   begin push_want = (grd == 8'd0) && !p1_reg; push_addr = g - w_cells; end
            S_N2_CHK:   begin push_want = (grd == 8'd0) && !p2_reg; push_addr = g + w_cells; end
            S_N3_CHK:   begin push_want = (grd == 8'd0) && !p3_reg; push_addr = g - layer_cells; end
            default:    ;
        endcase
        if (push_want && (sp_reg < SP_W'(STACK_DEPTH)))
        begin
            st_we    = 1'b1;
            st_addr  = sp_reg[SA_W-1:0];
            st_wdata = push_addr;
        end
    end

    logic is_water;
    assign is_water = (grd == cfg.water) || (grd == cfg.swater);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            sp_reg      <= '0;
            cnt_reg     <= '0;
            rval_reg    <= '0;
            ovf_reg     <= 1'b0;
            res_rv_reg  <= '0;
            res_cnt_reg <= '0;
            res_ovf_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        rval_reg <= '0;
                        cnt_reg  <= '0;
                        ovf_reg  <= 1'b0;
                        sp_reg   <= '0;
                        addr_reg <= idx;
                        v_reg    <= cell_value;
                        lava_reg <= (cell_value == cfg.lava) || (cell_value == cfg.slava);
                        case (req_type)
                            REQ_READ:  state_reg <= S_READ_WAIT;
                            REQ_FLOOD: state_reg <= (cell_value != 8'd0) ? S_SEED_RD : S_DONE;
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end
                S_READ_WAIT:
                begin
                    rval_reg  <= grd;
                    state_reg <= S_DONE;
                end
                S_SEED_RD:  state_reg <= S_SEED_CHK;
                S_SEED_CHK:
                begin
                    if (grd == 8'd0)
                    begin
                        sp_reg    <= SP_W'(1);
                        state_reg <= S_POP;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        sp_reg    <= sp_reg - SP_W'(1);
                        state_reg <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: state_reg <= S_POP_RD;
                S_POP_RD:
                begin
                    addr_reg  <= st_rdata & ~xmask;
                    c_reg     <= (X_BITS+1)'(st_rdata & xmask);
                    lo_reg    <= (X_BITS+1)'(st_rdata & xmask);
                    hi_reg    <= (X_BITS+1)'(st_rdata & xmask) + (X_BITS+1)'(1);
                    cz_reg    <= (st_rdata >> cfg.xl) & zmask;
                    cy_reg    <= HEIGHT_BITS'(st_rdata >> (cfg.xl + cfg.zl));
                    state_reg <= S_POP_CHK;
                end
                S_POP_CHK:  state_reg <= (grd != 8'd0) ? S_POP :
                                         (lo_reg == '0) ? S_HI_RD : S_LO_RD;
                S_LO_RD:    state_reg <= S_LO_CHK;
                S_LO_CHK:
                begin
                    if (grd == 8'd0)
                    begin
                        lo_reg    <= lo_reg - (X_BITS+1)'(1);
                        state_reg <= (lo_reg == (X_BITS+1)'(1)) ? S_HI_RD : S_LO_RD;
                    end
                    else
                        state_reg <= S_HI_RD;
                end
                S_HI_RD:
                begin
                    if (ADDR_W'(hi_reg) >= w_cells)
                    begin
                        c_reg     <= lo_reg;
                        p1_reg    <= 1'b0;
                        p2_reg    <= 1'b0;
                        p3_reg    <= 1'b0;
                        state_reg <= S_FILL_WR;
                    end
                    else
                        state_reg <= S_HI_CHK;
                end
                S_HI_CHK:
                begin
                    if (grd == 8'd0)
                    begin
                        hi_reg    <= hi_reg + (X_BITS+1)'(1);
                        state_reg <= S_HI_RD;
                    end
                    else
                    begin
                        c_reg     <= lo_reg;
                        p1_reg    <= 1'b0;
                        p2_reg    <= 1'b0;
                        p3_reg    <= 1'b0;
                        state_reg <= S_FILL_WR;
                    end
                end
                S_FILL_WR:
                begin
                    if (cnt_reg != COUNT_MAX)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    state_reg <= (cz_reg != '0) ? S_N1_RD :
                                 (cz_reg != zmask) ? S_N2_RD :
                                 (cy_reg != '0) ? S_N3_RD : S_NEXT;
                end
                S_N1_RD:    state_reg <= S_N1_CHK;
                S_N1_CHK:
                begin
                    if (push_want && (sp_reg >= SP_W'(STACK_DEPTH)))
                    begin
                        ovf_reg <= 1'b1; sp_reg <= '0; state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (push_want) sp_reg <= sp_reg + SP_W'(1);
                        p1_reg    <= (grd == 8'd0);
                        state_reg <= (cz_reg != zmask) ? S_N2_RD :
                                     (cy_reg != '0) ? S_N3_RD : S_NEXT;
                    end
                end
                S_N2_RD:    state_reg <= S_N2_CHK;
                S_N2_CHK:
                begin
                    if (push_want && (sp_reg >= SP_W'(STACK_DEPTH)))
                    begin
                        ovf_reg <= 1'b1; sp_reg <= '0; state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (push_want) sp_reg <= sp_reg + SP_W'(1);
                        p2_reg    <= (grd == 8'd0);
                        state_reg <= (cy_reg != '0) ? S_N3_RD : S_NEXT;
                    end
                end
                S_N3_RD:    state_reg <= S_N3_CHK;
                S_N3_CHK:
                begin
                    if (push_want && (sp_reg >= SP_W'(STACK_DEPTH)))
                    begin
                        ovf_reg <= 1'b1;
                        sp_reg  <= '0;
                    end
                    else if (push_want)
                        sp_reg <= sp_reg + SP_W'(1);
                    p3_reg <= (grd == 8'd0);
                    // stone goes in before an overflow ends the walk
                    if (lava_reg && is_water)
                        state_reg <= S_STONE_WR;
                    else if (push_want && (sp_reg >= SP_W'(STACK_DEPTH)))
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_NEXT;
                end
                S_STONE_WR: state_reg <= ovf_reg ? S_DONE : S_NEXT;
                S_NEXT:
                begin
                    if (c_reg + (X_BITS+1)'(1) < hi_reg)
                    begin
                        c_reg     <= c_reg + (X_BITS+1)'(1);
                        state_reg <= S_FILL_WR;
                    end
                    else
                        state_reg <= S_POP;
                end
                S_DONE:
                begin
                    // hold here until the result register is free
                    if (!ovalid_reg)
                    begin
                        ovalid_reg  <= 1'b1;
                        res_rv_reg  <= rval_reg;
                        res_cnt_reg <= cnt_reg;
                        res_ovf_reg <= ovf_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/vsff_checker.sv]
// Port-level checker for the flood fill block, bound to the top level.
`timescale 1ns / 1ps
module vsff_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import vsff_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    // with the result register free, a write passes through S_DONE and answers with an all-zero result
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_WRITE && !m_axis_tvalid |=> ##1
        m_axis_tvalid && m_axis_tdata == 32'd0)
        else $error("write result not zero after two cycles");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
        else $error("pad bits set");
endmodule

bind voxel_scanline_flood_fill vsff_checker u_vsff_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
